// ===== hw/rtl/temperature_trend_threat_classifier_defines.svh =====
// Assertion macros for the temperature trend threat classifier.
`ifndef TEMPERATURE_TREND_THREAT_CLASSIFIER_DEFINES_SVH
`define TEMPERATURE_TREND_THREAT_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ttc_pkg.sv =====
// Shared types and constants of the temperature trend threat classifier.
package ttc_pkg;

    localparam int TEMP_IN_W = 12;
    localparam int TEMP_W    = 11;
    localparam int HUM_W     = 10;
    localparam int TIME_W    = 48;
    localparam int STATUS_W  = 2;
    localparam int RATE_W    = 18;
    localparam int THREAT_W  = 3;
    localparam int LIM_W     = 17;
    localparam int FIRE_W    = 11;

    localparam int MAG_W     = 11;
    localparam int SCALE_W   = 26;
    localparam int NUM_W     = MAG_W + SCALE_W;
    localparam int DEN_W     = TIME_W;
    localparam int QUO_W     = 17;

    localparam logic [SCALE_W-1:0] US_PER_MINUTE   = 26'd60000000;
    localparam logic [TIME_W-1:0]  MIN_INTERVAL_US = 48'd600000;

    localparam logic [HUM_W-1:0]            HUM_MAX     = 10'd1000;
    localparam logic signed [TEMP_IN_W-1:0] TEMP_MIN    = -12'sd200;
    localparam logic signed [TEMP_IN_W-1:0] TEMP_MAX    = 12'sd800;
    localparam logic signed [12:0]          FIRE_MARGIN = 13'sd50;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [THREAT_W-1:0] THR_NONE     = 3'd0;
    localparam logic [THREAT_W-1:0] THR_LOW      = 3'd1;
    localparam logic [THREAT_W-1:0] THR_MEDIUM   = 3'd2;
    localparam logic [THREAT_W-1:0] THR_HIGH     = 3'd3;
    localparam logic [THREAT_W-1:0] THR_CRITICAL = 3'd4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_DRY      = 3'd0;
    localparam logic [2:0] REG_FIRE     = 3'd1;
    localparam logic [2:0] REG_RATE_LOW = 3'd2;
    localparam logic [2:0] REG_RATE_MED = 3'd3;
    localparam logic [2:0] REG_RATE_HI  = 3'd4;
    localparam logic [2:0] REG_RATE_CR  = 3'd5;

    localparam logic [HUM_W-1:0]         RST_DRY      = 10'd300;
    localparam logic signed [FIRE_W-1:0] RST_FIRE     = 11'sd600;
    localparam logic [LIM_W-1:0]         RST_RATE_LOW = 17'd10;
    localparam logic [LIM_W-1:0]         RST_RATE_MED = 17'd20;
    localparam logic [LIM_W-1:0]         RST_RATE_HI  = 17'd50;
    localparam logic [LIM_W-1:0]         RST_RATE_CR  = 17'd100;

    typedef struct packed {
        logic [HUM_W-1:0]         dry_humidity_limit;
        logic signed [FIRE_W-1:0] fire_temperature;
        logic [LIM_W-1:0]         rate_low_limit;
        logic [LIM_W-1:0]         rate_medium_limit;
        logic [LIM_W-1:0]         rate_high_limit;
        logic [LIM_W-1:0]         rate_critical_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [TIME_W-1:0]        stamp;
    } t_sample;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

// ===== hw/rtl/ttc_if.sv =====
// Valid/ready item channels for readings and results.
interface ttc_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     read_ok;
    logic signed [ttc_pkg::TEMP_IN_W-1:0]     temperature_tenths;
    logic [ttc_pkg::HUM_W-1:0]                humidity_tenths;
    logic [ttc_pkg::TIME_W-1:0]               time_us;

    modport source (output valid, read_ok, temperature_tenths, humidity_tenths, time_us,
                    input ready);
    modport sink   (input valid, read_ok, temperature_tenths, humidity_tenths, time_us,
                    output ready);
endinterface

interface ttc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [ttc_pkg::STATUS_W-1:0]         status;
    logic signed [ttc_pkg::RATE_W-1:0]    rise_rate;
    logic [ttc_pkg::THREAT_W-1:0]         threat_level;

    modport source (output valid, status, rise_rate, threat_level, input ready);
    modport sink   (input valid, status, rise_rate, threat_level, output ready);
endinterface

// ===== hw/rtl/temperature_trend_threat_classifier.sv =====
// Top level: reading check, rise rate from history memory, threat grading.
// One reading is in work at a time. A failed or out-of-range reading goes from
// acceptance to the done state. A valid reading passes the read, go and done
// states, with the divide state between go and done when a rise rate is computed
// (history at least half full and more than 600 ms since the oldest stored
// sample): the serial divider yields one quotient bit per cycle over the 37-bit
// scaled temperature delta. A new reading is taken while the previous result still
// waits in the output register. The history memory needs no clearing after reset.
`include "temperature_trend_threat_classifier_defines.svh"

module temperature_trend_threat_classifier #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ttc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ttc_pkg::DATA_W-1:0]  pwdata,
    output logic [ttc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    ttc_in_if.sink                      i_item,
    ttc_out_if.source                   o_result
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_GO   = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    ttc_pkg::t_cfg     cfg;
    ttc_pkg::t_sample  rd_sample;
    ttc_pkg::t_sample  wr_sample;
    ttc_pkg::t_div_req div_req;
    ttc_pkg::t_div_rsp div_rsp;
    logic              warm;

    logic [2:0]                         r_state;
    logic [ttc_pkg::STATUS_W-1:0]       r_status;
    logic signed [ttc_pkg::TEMP_W-1:0]  r_temp;
    logic [ttc_pkg::HUM_W-1:0]          r_hum;
    logic [ttc_pkg::TIME_W-1:0]         r_time;
    logic [ttc_pkg::TIME_W-1:0]         r_dt;
    logic [ttc_pkg::MAG_W-1:0]          r_mag;
    logic                               r_neg;
    logic                               r_en;
    logic signed [ttc_pkg::RATE_W-1:0]  r_rate;
    logic                               r_ov;
    logic [ttc_pkg::STATUS_W-1:0]       r_o_status;
    logic signed [ttc_pkg::RATE_W-1:0]  r_o_rate;
    logic [ttc_pkg::THREAT_W-1:0]       r_o_threat;

    logic                               accept;
    logic [ttc_pkg::STATUS_W-1:0]       in_status;
    logic                               load_out;
    logic                               wr_en;
    logic [ttc_pkg::TIME_W-1:0]         dt;
    logic signed [ttc_pkg::TEMP_IN_W-1:0] dtemp;
    logic [ttc_pkg::TEMP_IN_W-1:0]      dtemp_abs;
    logic [ttc_pkg::RATE_W-1:0]         quo_ext;
    logic signed [12:0]                 temp_x;
    logic signed [12:0]                 fire_x;
    logic signed [ttc_pkg::RATE_W-1:0]  lim_low;
    logic signed [ttc_pkg::RATE_W-1:0]  lim_med;
    logic signed [ttc_pkg::RATE_W-1:0]  lim_hi;
    logic signed [ttc_pkg::RATE_W-1:0]  lim_cr;
    logic                               dry;
    logic [ttc_pkg::THREAT_W-1:0]       threat;

    ttc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ttc_ring #(.DEPTH(HISTORY_DEPTH)) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_wr_en   (wr_en),
        .i_wr_data (wr_sample),
        .o_rd_data (rd_sample),
        .o_warm    (warm)
    );

    ttc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && (r_state == S_IDLE);

    always_comb begin
        if (!i_item.read_ok) begin
            in_status = ttc_pkg::ST_FAIL;
        end else if (i_item.humidity_tenths > ttc_pkg::HUM_MAX
                     || i_item.temperature_tenths < ttc_pkg::TEMP_MIN
                     || i_item.temperature_tenths > ttc_pkg::TEMP_MAX) begin
            in_status = ttc_pkg::ST_RANGE;
        end else begin
            in_status = ttc_pkg::ST_OK;
        end
    end

    // delta against the oldest sample
    assign dt        = r_time - rd_sample.stamp;
    assign dtemp     = ttc_pkg::TEMP_IN_W'(r_temp) - ttc_pkg::TEMP_IN_W'(rd_sample.temp);
    assign dtemp_abs = dtemp[ttc_pkg::TEMP_IN_W-1] ? -dtemp : dtemp;

    assign div_req.start = (r_state == S_GO) && r_en;
    assign div_req.num   = ttc_pkg::NUM_W'(r_mag) * ttc_pkg::NUM_W'(ttc_pkg::US_PER_MINUTE);
    assign div_req.den   = r_dt;

    assign quo_ext = ttc_pkg::RATE_W'(div_rsp.quo);

    assign load_out = (r_state == S_DONE) && (!r_ov || o_result.ready);
    assign wr_en    = load_out && (r_status == ttc_pkg::ST_OK);

    assign wr_sample.temp  = r_temp;
    assign wr_sample.stamp = r_time;

    // threat grading
    assign temp_x  = 13'(r_temp);
    assign fire_x  = 13'(cfg.fire_temperature);
    assign lim_low = $signed({1'b0, cfg.rate_low_limit});
    assign lim_med = $signed({1'b0, cfg.rate_medium_limit});
    assign lim_hi  = $signed({1'b0, cfg.rate_high_limit});
    assign lim_cr  = $signed({1'b0, cfg.rate_critical_limit});
    assign dry     = (r_hum <= cfg.dry_humidity_limit);

    always_comb begin
        if (temp_x >= fire_x && dry) begin
            threat = ttc_pkg::THR_HIGH;
        end else if (temp_x >= fire_x) begin
            threat = ttc_pkg::THR_MEDIUM;
        end else if (temp_x >= fire_x - ttc_pkg::FIRE_MARGIN) begin
            threat = ttc_pkg::THR_LOW;
        end else begin
            threat = ttc_pkg::THR_NONE;
        end

        priority if (r_rate >= lim_cr) begin
            threat = ttc_pkg::THR_CRITICAL;
        end else if (r_rate >= lim_hi) begin
            if (threat < ttc_pkg::THR_HIGH) threat = ttc_pkg::THR_HIGH;
        end else if (r_rate >= lim_med) begin
            if (threat < ttc_pkg::THR_MEDIUM) threat = ttc_pkg::THR_MEDIUM;
        end else if (r_rate >= lim_low) begin
            if (threat < ttc_pkg::THR_LOW) threat = ttc_pkg::THR_LOW;
        end else begin
        end

        if (dry && r_rate >= lim_med && threat < ttc_pkg::THR_HIGH) begin
            threat = ttc_pkg::THR_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (in_status == ttc_pkg::ST_OK) ? S_RD : S_DONE;
                    end
                end
                S_RD:   r_state <= S_GO;
                S_GO:   r_state <= r_en ? S_DIV : S_DONE;
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= in_status;
            r_temp   <= i_item.temperature_tenths[ttc_pkg::TEMP_W-1:0];
            r_hum    <= i_item.humidity_tenths;
            r_time   <= i_item.time_us;
            r_rate   <= '0;
        end
        if (r_state == S_RD) begin
            r_dt  <= dt;
            r_mag <= dtemp_abs[ttc_pkg::MAG_W-1:0];
            r_neg <= dtemp[ttc_pkg::TEMP_IN_W-1];
            r_en  <= warm && (dt > ttc_pkg::MIN_INTERVAL_US);
        end
        if (r_state == S_DIV && div_rsp.done) begin
            r_rate <= r_neg ? -$signed(quo_ext) : $signed(quo_ext);
        end
        if (load_out) begin
            r_o_status <= r_status;
            r_o_rate   <= (r_status == ttc_pkg::ST_OK) ? r_rate : '0;
            r_o_threat <= (r_status == ttc_pkg::ST_OK) ? threat : ttc_pkg::THR_NONE;
        end
    end

    assign o_result.valid        = r_ov;
    assign o_result.status       = r_o_status;
    assign o_result.rise_rate    = r_o_rate;
    assign o_result.threat_level = r_o_threat;

    `TTC_ASSERT_IMPLY(a_reject_zero, i_clk, i_rst_n, r_ov && r_o_status != ttc_pkg::ST_OK, r_o_rate == '0 && r_o_threat == ttc_pkg::THR_NONE, "rejected item carries rate or threat")
    `TTC_ASSERT_NEXT(a_read_follows, i_clk, i_rst_n, accept && in_status == ttc_pkg::ST_OK, r_state == S_RD, "valid item did not read history")
    `TTC_ASSERT_IMPLY(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy, "divider started while busy")
    `TTC_ASSERT_IMPLY(a_write_ok_only, i_clk, i_rst_n, wr_en, r_state == S_DONE && r_status == ttc_pkg::ST_OK, "history written by a rejected item")
endmodule

// ===== hw/rtl/ttc_cfg.sv =====
// APB configuration registers: thresholds and rate limits.
module ttc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ttc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ttc_pkg::DATA_W-1:0]  pwdata,
    output logic [ttc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ttc_pkg::t_cfg               o_cfg
);
    ttc_pkg::t_cfg r_cfg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dry_humidity_limit  <= ttc_pkg::RST_DRY;
            r_cfg.fire_temperature    <= ttc_pkg::RST_FIRE;
            r_cfg.rate_low_limit      <= ttc_pkg::RST_RATE_LOW;
            r_cfg.rate_medium_limit   <= ttc_pkg::RST_RATE_MED;
            r_cfg.rate_high_limit     <= ttc_pkg::RST_RATE_HI;
            r_cfg.rate_critical_limit <= ttc_pkg::RST_RATE_CR;
        end else if (wr) begin
            unique case (idx)
                ttc_pkg::REG_DRY:      r_cfg.dry_humidity_limit  <= pwdata[ttc_pkg::HUM_W-1:0];
                ttc_pkg::REG_FIRE:     r_cfg.fire_temperature    <= pwdata[ttc_pkg::FIRE_W-1:0];
                ttc_pkg::REG_RATE_LOW: r_cfg.rate_low_limit      <= pwdata[ttc_pkg::LIM_W-1:0];
                ttc_pkg::REG_RATE_MED: r_cfg.rate_medium_limit   <= pwdata[ttc_pkg::LIM_W-1:0];
                ttc_pkg::REG_RATE_HI:  r_cfg.rate_high_limit     <= pwdata[ttc_pkg::LIM_W-1:0];
                ttc_pkg::REG_RATE_CR:  r_cfg.rate_critical_limit <= pwdata[ttc_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ttc_pkg::REG_DRY:      prdata = ttc_pkg::DATA_W'(r_cfg.dry_humidity_limit);
            ttc_pkg::REG_FIRE:     prdata = ttc_pkg::DATA_W'(r_cfg.fire_temperature);
            ttc_pkg::REG_RATE_LOW: prdata = ttc_pkg::DATA_W'(r_cfg.rate_low_limit);
            ttc_pkg::REG_RATE_MED: prdata = ttc_pkg::DATA_W'(r_cfg.rate_medium_limit);
            ttc_pkg::REG_RATE_HI:  prdata = ttc_pkg::DATA_W'(r_cfg.rate_high_limit);
            ttc_pkg::REG_RATE_CR:  prdata = ttc_pkg::DATA_W'(r_cfg.rate_critical_limit);
            default:               prdata = '0;
        endcase
    end
endmodule

// ===== hw/rtl/ttc_ring.sv =====
// Sample history memory with write slot and fill count.
`include "temperature_trend_threat_classifier_defines.svh"

module ttc_ring #(
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic             i_wr_en,
    input  ttc_pkg::t_sample i_wr_data,
    output ttc_pkg::t_sample o_rd_data,
    output logic             o_warm
);
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    ttc_pkg::t_sample  r_mem [DEPTH];
    ttc_pkg::t_sample  r_rd_data;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [SLOT_W-1:0] tail;
    logic              full;

    // oldest entry: slot zero until the ring wraps, the write slot after
    assign full      = (r_count == CNT_W'(DEPTH));
    assign tail      = full ? r_slot : '0;
    assign o_warm    = (r_count >= CNT_W'(DEPTH / 2));
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_slot] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[tail];
        end
    end

    always_comb begin
        n_slot  = r_slot;
        n_count = r_count;
        if (i_wr_en) begin
            n_slot = (r_slot == SLOT_W'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
            if (!full) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
        end else begin
            r_slot  <= n_slot;
            r_count <= n_count;
        end
    end

    `TTC_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "fill count over depth")
    `TTC_ASSERT_IMPLY(a_slot_bound, i_clk, i_rst_n, 1'b1, r_slot <= SLOT_W'(DEPTH - 1), "slot over depth")
    `TTC_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_wr_en && !full, r_count == $past(r_count) + 1'b1, "fill count missed a write")
endmodule

// ===== hw/rtl/ttc_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module ttc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttc_pkg::t_div_req i_req,
    output ttc_pkg::t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(ttc_pkg::NUM_W + 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [ttc_pkg::DEN_W-1:0] r_rem;
    logic [ttc_pkg::NUM_W-1:0] r_q;
    logic [ttc_pkg::DEN_W-1:0] r_den;
    logic [ttc_pkg::DEN_W:0]   trial;
    logic [ttc_pkg::DEN_W:0]   diff;
    logic                      fits;

    assign trial = {r_rem, r_q[ttc_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q[ttc_pkg::QUO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ttc_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[ttc_pkg::DEN_W-1:0] : trial[ttc_pkg::DEN_W-1:0];
            r_q   <= {r_q[ttc_pkg::NUM_W-2:0], fits};
        end
    end
endmodule
